// ----- design/htf_pkg.sv -----
package htf_pkg;

  localparam int LENGTH_BITS = 12;
  localparam int KEY_LEN_W   = 12;
  localparam int VAL_W       = 13;
  localparam int PHASE_W     = 4;

  localparam logic [LENGTH_BITS-1:0] KEY_CAP = {LENGTH_BITS{1'b1}};
  localparam logic [VAL_W-1:0]       VALUE_LIMIT_RESET = VAL_W'(256);

  // parse phases
  localparam logic [PHASE_W-1:0] PH_START  = 4'd0;
  localparam logic [PHASE_W-1:0] PH_KEY    = 4'd1;
  localparam logic [PHASE_W-1:0] PH_COLON  = 4'd2;
  localparam logic [PHASE_W-1:0] PH_SPACE  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_VALUE  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_CR     = 4'd5;
  localparam logic [PHASE_W-1:0] PH_LF     = 4'd6;
  localparam logic [PHASE_W-1:0] PH_END_CR = 4'd7;
  localparam logic [PHASE_W-1:0] PH_BODY   = 4'd8;
  localparam logic [PHASE_W-1:0] PH_ERROR  = 4'd9;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [1:0] ROLE_DELIM = 2'd0;
  localparam logic [1:0] ROLE_KEY   = 2'd1;
  localparam logic [1:0] ROLE_VALUE = 2'd2;
  localparam logic [1:0] ROLE_BODY  = 2'd3;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_FIELD = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;
  localparam logic [1:0] EV_ERROR = 2'd3;

  typedef struct packed {
    logic [PHASE_W-1:0]     phase;
    logic [LENGTH_BITS-1:0] key_count;
    logic [VAL_W-1:0]       value_count;
    logic [1:0]             role;
    logic [1:0]             event_res;
    logic [KEY_LEN_W-1:0]   key_length;
    logic [VAL_W-1:0]       value_length;
  } htf_step_t;

  // reported key length saturates at the width of the key_length field
  function automatic logic [KEY_LEN_W-1:0] key_len_sat(input logic [LENGTH_BITS-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    if (wide > 32'({KEY_LEN_W{1'b1}})) begin
      key_len_sat = {KEY_LEN_W{1'b1}};
    end else begin
      key_len_sat = wide[KEY_LEN_W-1:0];
    end
  endfunction

endpackage

// ----- design/htf_step.sv -----
module htf_step (
  input  logic [htf_pkg::PHASE_W-1:0]     phase,
  input  logic [htf_pkg::LENGTH_BITS-1:0] key_count,
  input  logic [htf_pkg::VAL_W-1:0]       value_count,
  input  logic [htf_pkg::VAL_W-1:0]       value_limit,
  input  logic [7:0]                      data_byte,
  input  logic                            new_request,
  output htf_pkg::htf_step_t              step
);
  import htf_pkg::*;

  logic [PHASE_W-1:0]     ph;
  logic [LENGTH_BITS-1:0] kc;
  logic [VAL_W-1:0]       vc;
  logic                   is_eol;

  assign is_eol = data_byte inside {CH_CR, CH_LF};

  always_comb begin
    // a new request restarts before the byte is handled
    ph = new_request ? PH_START : phase;
    kc = new_request ? '0 : key_count;
    vc = new_request ? '0 : value_count;

    step = '0;
    step.phase       = ph;
    step.key_count   = kc;
    step.value_count = vc;
    step.role        = ROLE_DELIM;
    step.event_res   = EV_NONE;

    case (ph)
      PH_START: begin
        if (!is_eol) begin
          step.phase     = PH_KEY;
          step.key_count = LENGTH_BITS'(1);
          step.role      = ROLE_KEY;
        end
      end
      PH_KEY: begin
        if (data_byte == CH_COLON) begin
          step.phase = (kc == '0) ? PH_ERROR : PH_COLON;
        end else if (is_eol) begin
          step.phase = PH_ERROR;
        end else begin
          if (kc != KEY_CAP) begin
            step.key_count = kc + LENGTH_BITS'(1);
          end
          step.role = ROLE_KEY;
        end
      end
      PH_COLON: begin
        step.phase = (data_byte == CH_SPACE) ? PH_SPACE : PH_ERROR;
      end
      PH_SPACE: begin
        // the first value byte is taken whatever it is
        step.phase       = PH_VALUE;
        step.value_count = VAL_W'(1);
        step.role        = ROLE_VALUE;
      end
      PH_VALUE: begin
        if (data_byte == CH_CR) begin
          step.phase = PH_CR;
        end else if (vc >= value_limit) begin
          step.phase = PH_ERROR;
        end else begin
          step.value_count = vc + VAL_W'(1);
          step.role        = ROLE_VALUE;
        end
      end
      PH_CR: begin
        if (data_byte == CH_LF) begin
          step.phase        = PH_LF;
          step.event_res    = EV_FIELD;
          step.key_length   = key_len_sat(kc);
          step.value_length = vc;
        end else begin
          step.phase = PH_ERROR;
        end
      end
      PH_LF: begin
        if (data_byte == CH_CR) begin
          step.phase = PH_END_CR;
        end else begin
          step.phase     = PH_KEY;
          step.key_count = LENGTH_BITS'(1);
          step.role      = ROLE_KEY;
        end
      end
      PH_END_CR: begin
        if (data_byte == CH_LF) begin
          step.phase     = PH_BODY;
          step.event_res = EV_END;
        end else begin
          step.phase = PH_ERROR;
        end
      end
      PH_BODY: begin
        step.role = ROLE_BODY;
      end
      default: begin
        step.phase = PH_ERROR;
      end
    endcase

    // errors are sticky and blank the result
    if (step.phase == PH_ERROR) begin
      step.role         = ROLE_DELIM;
      step.event_res    = EV_ERROR;
      step.key_length   = '0;
      step.value_length = '0;
    end
  end

endmodule

// ----- design/http_header_field_tokenizer_unit.sv -----
// HTTP header tokenizer: takes one header byte per item and returns one result item per byte,
// echoing the byte with its role (key, value, body or delimiter) and an event (field done with
// its key and value lengths, end of headers on the final LF, or a sticky error that holds until
// an item with new_request set). A byte is accepted every cycle unless a held result stalls it;
// each one passes through an input register and the parse step into the result register, and
// the only loop is the phase and counter update. The user must write value_limit through
// cfg_wr_en / cfg_wr_data only while no item is in flight; the block itself does not enforce it.
module http_header_field_tokenizer_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [htf_pkg::VAL_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                data_byte,
  input  logic                      new_request,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                echo_byte,
  output logic [1:0]                role,
  output logic [1:0]                event_res,
  output logic [htf_pkg::KEY_LEN_W-1:0] key_length,
  output logic [htf_pkg::VAL_W-1:0] value_length
);
  import htf_pkg::*;

  logic [VAL_W-1:0]       value_limit;
  logic [PHASE_W-1:0]     phase;
  logic [LENGTH_BITS-1:0] key_count;
  logic [VAL_W-1:0]       value_count;

  logic       in_vld;
  logic [7:0] in_byte;
  logic       in_new;

  logic       out_free;
  logic       advance;
  htf_step_t  step;

  assign out_free = !out_valid || out_ready;
  assign advance  = in_vld && out_free;
  assign in_ready = !in_vld || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_limit <= VALUE_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      value_limit <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte <= data_byte;
      in_new  <= new_request;
    end
  end

  htf_step u_step (
    .phase       (phase),
    .key_count   (key_count),
    .value_count (value_count),
    .value_limit (value_limit),
    .data_byte   (in_byte),
    .new_request (in_new),
    .step        (step)
  );

  // parse state moves only when the item goes into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      key_count   <= '0;
      value_count <= '0;
    end else if (advance) begin
      phase       <= step.phase;
      key_count   <= step.key_count;
      value_count <= step.value_count;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      echo_byte    <= in_byte;
      role         <= step.role;
      event_res    <= step.event_res;
      key_length   <= step.key_length;
      value_length <= step.value_length;
    end
  end

  // a completed field always has at least one value byte
  a_field_has_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_FIELD |-> value_length != '0)
    else $error("field reported with empty value");

  a_lengths_only_on_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_FIELD |-> key_length == '0 && value_length == '0)
    else $error("lengths reported without a completed field");

  a_error_role: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_ERROR |-> role == ROLE_DELIM)
    else $error("error item carries a non-delimiter role");

  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(phase) && $stable(key_count) && $stable(value_count))
    else $error("parse state moved without an item");

endmodule
